@@ sv/trajectory_gap_interpolator_core_macros.svh @@
// Assertion macros for the trajectory gap interpolator.
`ifndef TRAJECTORY_GAP_INTERPOLATOR_CORE_MACROS_SVH
`define TRAJECTORY_GAP_INTERPOLATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TGI_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define TGI_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TGI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TGI_ASSERT_ALWAYS(label, cond, msg)
`define TGI_ASSERT_IMPL(label, ante, cons, msg)
`define TGI_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ sv/tgi_pkg.sv @@
// Types and constants shared by the trajectory gap interpolator files.
`default_nettype none
package tgi_pkg;
	localparam int GAP_DEPTH = 32;
	localparam int GAP_AW = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;
	localparam int FILL_W = $clog2(GAP_DEPTH + 1);

	localparam logic [1:0] KIND_MEASURED = 2'd0;
	localparam logic [1:0] KIND_INTERP = 2'd1;
	localparam logic [1:0] KIND_UNFILLED = 2'd2;

	typedef struct packed {
		logic [31:0] sample_time;
		logic present;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [7:0] phase_tag;
		logic end_of_track;
	} sample_t;

	typedef struct packed {
		logic [31:0] out_time;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [7:0] out_phase;
		logic [1:0] out_kind;
		logic out_last;
	} result_t;

	typedef struct packed {
		logic [31:0] gtime;
		logic [7:0] phase;
	} gap_entry_t;
endpackage
`default_nettype wire

@@ sv/tgi_if.sv @@
// Valid/ready channel interfaces for samples and results.
`default_nettype none
interface tgi_sample_if;
	import tgi_pkg::*;
	logic valid;
	logic ready;
	sample_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tgi_result_if;
	import tgi_pkg::*;
	logic valid;
	logic ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/trajectory_gap_interpolator_core.sv @@
// Trajectory gap interpolator: buffers missing samples and fills them linearly.
// A missing sample behind a known knot, not at end of track and with room in the
// gap memory, is written there and gives no word. Any other sample starts a pass
// over the buffered entries: each entry is read from the memory (READ, LOAD) and
// emitted; a filled entry also runs a shift-add multiply, a rounding add and a
// restoring divide, all three axes in parallel. The pass ends with the word
// of the sample itself.
// The block takes a new sample only when its pass is over; one output
// register lets it go on while the last word waits. No clearing pass:
// entries are read only below the fill count.
`default_nettype none
`include "trajectory_gap_interpolator_core_macros.svh"
module trajectory_gap_interpolator_core (
	input wire logic clk,
	input wire logic arst_n,
	tgi_sample_if.sink sample_ch,
	tgi_result_if.source result_ch
);
	import tgi_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_MUL = 3'd3;
	localparam logic [2:0] ST_RND = 3'd4;
	localparam logic [2:0] ST_DIV = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;
	localparam logic [2:0] ST_FINAL = 3'd7;

	logic [2:0] state_q;
	sample_t cur_q;
	logic interp_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] idx_q;
	logic [5:0] cnt_q;
	logic [31:0] dt_q;
	logic [31:0] e_q;
	logic [31:0] bt_q;
	logic [7:0] bph_q;

	logic knot_valid_q;
	logic [31:0] knot_time_q;
	logic signed [31:0] knot_pos_q [3];

	logic [32:0] mag_q [3];
	logic neg_q [3];
	logic [65:0] acc_q [3];
	logic [31:0] rem_q [3];
	logic [32:0] shr_q [3];
	logic [32:0] quot_q [3];

	gap_entry_t gap_mem [GAP_DEPTH];
	gap_entry_t rd_q;

	logic out_valid_q;
	result_t out_q;

	logic signed [31:0] in_pos [3];
	logic signed [31:0] fill_pos [3];
	logic take, buffer_it, slot_free;
	logic word_go;
	logic [31:0] e_raw;

	assign in_pos[0] = sample_ch.data.pos_x;
	assign in_pos[1] = sample_ch.data.pos_y;
	assign in_pos[2] = sample_ch.data.pos_z;

	assign sample_ch.ready = (state_q == ST_IDLE);
	assign take = sample_ch.valid && sample_ch.ready;
	assign buffer_it = !sample_ch.data.present && knot_valid_q
		&& !sample_ch.data.end_of_track && (fill_q < FILL_W'(GAP_DEPTH));
	assign slot_free = !out_valid_q || result_ch.ready;
	// load a word into the output register this cycle
	assign word_go = slot_free && (state_q == ST_EMIT || state_q == ST_FINAL);

	assign result_ch.valid = out_valid_q;
	assign result_ch.data = out_q;

	// offset of the buffered sample from the knot, clamped to the segment
	always_comb begin
		e_raw = (rd_q.gtime > knot_time_q) ? (rd_q.gtime - knot_time_q) : 32'd0;
		if (e_raw > dt_q) begin
			e_raw = dt_q;
		end
	end

	// knot plus or minus the rounded quotient, per axis
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			logic [33:0] sum;
			logic [33:0] qx;
			qx = {1'b0, quot_q[l]};
			sum = {{2{knot_pos_q[l][31]}}, knot_pos_q[l]} + (neg_q[l] ? -qx : qx);
			fill_pos[l] = (dt_q == 32'd0) ? knot_pos_q[l] : sum[31:0];
		end
	end

	// gap memory: write on buffering, registered read at the pass index
	always_ff @(posedge clk) begin
		if (take && buffer_it) begin
			gap_mem[fill_q[GAP_AW-1:0]] <= '{gtime: sample_ch.data.sample_time,
				phase: sample_ch.data.phase_tag};
		end
		rd_q <= gap_mem[idx_q[GAP_AW-1:0]];
	end

	// datapath registers: no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= sample_ch.data;
			interp_q <= sample_ch.data.present && knot_valid_q;
			dt_q <= (sample_ch.data.sample_time > knot_time_q)
				? (sample_ch.data.sample_time - knot_time_q) : 32'd0;
			for (int l = 0; l < 3; l++) begin
				logic [32:0] d;
				d = {in_pos[l][31], in_pos[l]} - {knot_pos_q[l][31], knot_pos_q[l]};
				neg_q[l] <= d[32];
				mag_q[l] <= d[32] ? -d : d;
			end
		end
		unique case (state_q)
			ST_LOAD: begin
				bt_q <= rd_q.gtime;
				bph_q <= rd_q.phase;
				e_q <= e_raw;
				for (int l = 0; l < 3; l++) begin
					acc_q[l] <= '0;
				end
			end
			ST_MUL: begin
				e_q <= {e_q[30:0], 1'b0};
				for (int l = 0; l < 3; l++) begin
					acc_q[l] <= {acc_q[l][64:0], 1'b0}
						+ (e_q[31] ? {33'd0, mag_q[l]} : 66'd0);
				end
			end
			ST_RND: begin
				for (int l = 0; l < 3; l++) begin
					logic [65:0] num;
					num = acc_q[l] + {35'd0, dt_q[31:1]};
					rem_q[l] <= num[64:33];
					shr_q[l] <= num[32:0];
					quot_q[l] <= '0;
				end
			end
			ST_DIV: begin
				for (int l = 0; l < 3; l++) begin
					logic [32:0] rs;
					logic [32:0] df;
					logic ge;
					rs = {rem_q[l], shr_q[l][32]};
					ge = (rs >= {1'b0, dt_q});
					df = rs - {1'b0, dt_q};
					rem_q[l] <= ge ? df[31:0] : rs[31:0];
					quot_q[l] <= {quot_q[l][31:0], ge};
					shr_q[l] <= {shr_q[l][31:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
		if (slot_free && state_q == ST_EMIT) begin
			out_q.out_time <= bt_q;
			out_q.out_phase <= bph_q;
			out_q.out_kind <= interp_q ? KIND_INTERP : KIND_UNFILLED;
			out_q.out_x <= interp_q ? fill_pos[0] : 32'sd0;
			out_q.out_y <= interp_q ? fill_pos[1] : 32'sd0;
			out_q.out_z <= interp_q ? fill_pos[2] : 32'sd0;
			out_q.out_last <= 1'b0;
		end else if (slot_free && state_q == ST_FINAL) begin
			out_q.out_time <= cur_q.sample_time;
			out_q.out_phase <= cur_q.phase_tag;
			out_q.out_kind <= cur_q.present ? KIND_MEASURED : KIND_UNFILLED;
			out_q.out_x <= cur_q.present ? cur_q.pos_x : 32'sd0;
			out_q.out_y <= cur_q.present ? cur_q.pos_y : 32'sd0;
			out_q.out_z <= cur_q.present ? cur_q.pos_z : 32'sd0;
			out_q.out_last <= 1'b1;
		end
	end

	// control: sequencer, counters, knot and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
			knot_valid_q <= 1'b0;
			knot_time_q <= '0;
			for (int l = 0; l < 3; l++) begin
				knot_pos_q[l] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			// hold the word until taken, then load the next one or drop valid
			if (word_go) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						idx_q <= '0;
						if (buffer_it) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							state_q <= (fill_q != '0) ? ST_READ : ST_FINAL;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					cnt_q <= '0;
					state_q <= (interp_q && dt_q != 32'd0) ? ST_MUL : ST_EMIT;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd31) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd32) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						idx_q <= idx_q + 1'b1;
						state_q <= (idx_q + 1'b1 == fill_q) ? ST_FINAL : ST_READ;
					end
				end
				ST_FINAL: begin
					if (slot_free) begin
						fill_q <= '0;
						state_q <= ST_IDLE;
						if (cur_q.present) begin
							knot_valid_q <= !cur_q.end_of_track;
							knot_time_q <= cur_q.sample_time;
							knot_pos_q[0] <= cur_q.pos_x;
							knot_pos_q[1] <= cur_q.pos_y;
							knot_pos_q[2] <= cur_q.pos_z;
						end else begin
							knot_valid_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TGI_ASSERT_ALWAYS(a_fill_range, fill_q <= FILL_W'(GAP_DEPTH), "gap fill above depth")
	`TGI_ASSERT_IMPL(a_no_orphan_gap, !knot_valid_q && state_q == ST_IDLE, fill_q == '0, "gap without knot")
	`TGI_ASSERT_NEXT(a_buffer_step, take && buffer_it, fill_q == $past(fill_q) + 1'b1, "gap not counted")
	`TGI_ASSERT_IMPL(a_quot_x, state_q == ST_EMIT && interp_q && dt_q != 32'd0, quot_q[0] <= mag_q[0], "x step beyond segment")
	`TGI_ASSERT_IMPL(a_quot_y, state_q == ST_EMIT && interp_q && dt_q != 32'd0, quot_q[1] <= mag_q[1], "y step beyond segment")
endmodule
`default_nettype wire
